@@ hw/rtl/pfprr_pkg.sv @@
// ----------------------------------------------------------------------------
// pfprr_pkg
// Shared widths, register indexes and the remainder step of the per-flow
// round-robin path selector.
// ----------------------------------------------------------------------------
package pfprr_pkg;

  localparam int FLOW_ID_W        = 32;
  localparam int FLOW_ENTRIES_DEF = 1024;
  localparam int MAX_PATHS        = 8;
  localparam int CNT_W            = 4;
  localparam int PIDX_W           = 3;
  localparam int CORE_ADDR_W      = 32;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PATH_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_0     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_1     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_2     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_3     = 3'd4;

  localparam int              LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Remainder unit: dividend bits consumed per cycle and steps per request.
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = LFSR_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // Restoring remainder over MOD_BITS dividend bits, most significant first.
  // The partial remainder stays below cnt, which is at most MAX_PATHS.
  function automatic logic [PIDX_W-1:0] mod_step(input logic [PIDX_W-1:0]   rem,
                                                 input logic [MOD_BITS-1:0] bits,
                                                 input logic [CNT_W-1:0]    cnt);
    logic [PIDX_W-1:0] r;
    logic [CNT_W-1:0]  t;
    r = rem;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= cnt) begin
        t = t - cnt;
      end
      r = t[PIDX_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/per_flow_path_round_robin.sv @@
// ----------------------------------------------------------------------------
// per_flow_path_round_robin
// Picks a core path for each flow id, rotating through the configured path
// slots per flow; new flows start at a pseudo-random slot.
// ----------------------------------------------------------------------------
//  channel   direction  signals                                 content
//  s_*       in         s_tvalid s_tready s_tdata               flow id
//  m_*       out        m_tvalid m_tready m_tdata m_tuser       chosen path
//  APB       in/out     psel penable pwrite paddr pwdata ...    path count, addresses
//
//  A request passes through acceptance with its flow table read, a lookup
//  state, the remainder unit (four dividend bits per cycle) and a write-back
//  state. With no path configured a request goes straight from acceptance to
//  the output stage, skipping lookup, remainder and the flow table write.
//  After reset a clearing pass walks all FLOW_ENTRIES entries of the flow
//  table (1024 by default) with s_tready low; register writes are taken.
//  A result that is not taken holds in the output register; the next request
//  is accepted meanwhile and waits at write-back until the register frees.
//  FLOW_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module per_flow_path_round_robin #(
  parameter int FLOW_ENTRIES = pfprr_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // flow stream in
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pfprr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] flow_id
  // path stream out
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pfprr_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] core_address,
                                                          // [34:32] path_index,
                                                          // [39:35] zero
  output logic [pfprr_pkg::OUT_TUSER_W-1:0]    m_tuser,   // [0] new_flow, [1] no_path
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pfprr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pfprr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pfprr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import pfprr_pkg::*;

  localparam int ENT_W   = $clog2(FLOW_ENTRIES);
  localparam int TAG_W   = FLOW_ID_W - ENT_W;
  localparam int WORD_W  = 1 + TAG_W + PIDX_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_MOD, S_DONE} state_t;

  // Registers
  logic [CNT_W-1:0]       path_count;
  logic [CFG_DATA_W-1:0]  path_addr_pair [4];
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_count <= '0;
      for (int k = 0; k < 4; k++) begin
        path_addr_pair[k] <= '0;
      end
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_PATH_COUNT: path_count        <= pwdata[CNT_W-1:0];
        REG_PAIR_0:     path_addr_pair[0] <= pwdata;
        REG_PAIR_1:     path_addr_pair[1] <= pwdata;
        REG_PAIR_2:     path_addr_pair[2] <= pwdata;
        REG_PAIR_3:     path_addr_pair[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATH_COUNT: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, path_count};
      REG_PAIR_0:     prdata = path_addr_pair[0];
      REG_PAIR_1:     prdata = path_addr_pair[1];
      REG_PAIR_2:     prdata = path_addr_pair[2];
      REG_PAIR_3:     prdata = path_addr_pair[3];
      default:        prdata = '0;
    endcase
  end

  // Effective path count, clamped to the number of slots.
  logic [CNT_W-1:0] cnt_eff;
  assign cnt_eff = (path_count > CNT_W'(MAX_PATHS)) ? CNT_W'(MAX_PATHS) : path_count;

  // Flow table: {valid, tag, next index}
  logic [WORD_W-1:0] flow_mem [FLOW_ENTRIES];
  logic [WORD_W-1:0] rd_word;
  logic              mem_we;
  logic [ENT_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              rd_en;

  state_t               state;
  logic [ENT_W-1:0]     clr_addr;
  logic [ENT_W-1:0]     entry_q;
  logic [TAG_W-1:0]     tag_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 known_q;
  logic                 nopath_q;
  logic [LFSR_W-1:0]    dvd;
  logic [PIDX_W-1:0]    rem;
  logic [PIDX_W-1:0]    rem_next;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [LFSR_W-1:0]    lfsr;
  logic [LFSR_W-1:0]    lfsr_next;
  logic                 rd_hit;
  logic [PIDX_W-1:0]    idx_next;
  logic [CFG_DATA_W-1:0] pair_sel;
  logic [CORE_ADDR_W-1:0] addr_sel;
  logic                 out_free;

  assign s_tready = (state == S_IDLE);
  assign rd_en    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign rd_hit   = rd_word[WORD_W-1] && (rd_word[WORD_W-2:PIDX_W] == tag_q);
  assign rem_next = mod_step(rem, dvd[LFSR_W-1:LFSR_W-MOD_BITS], cnt_q);
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};

  // The index after the chosen one, wrapping at the path count.
  assign idx_next = ({1'b0, rem} + 1'b1 >= cnt_q) ? '0 : rem + 1'b1;

  assign pair_sel = path_addr_pair[rem[PIDX_W-1:1]];
  assign addr_sel = rem[0] ? pair_sel[CFG_DATA_W-1:CORE_ADDR_W]
                           : pair_sel[CORE_ADDR_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_q;
    mem_wdata = {1'b1, tag_q, idx_next};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_DONE && out_free && !nopath_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      flow_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_word <= flow_mem[s_tdata[ENT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      lfsr     <= LFSR_SEED;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(state == S_DONE && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {ENT_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rd_en) begin
            entry_q  <= s_tdata[ENT_W-1:0];
            tag_q    <= s_tdata[FLOW_ID_W-1:ENT_W];
            cnt_q    <= cnt_eff;
            nopath_q <= (cnt_eff == '0);
            state    <= (cnt_eff == '0) ? S_DONE : S_LOOK;
          end
        end
        S_LOOK: begin
          // A known flow reduces its stored index, a new one the LFSR value.
          known_q <= rd_hit;
          dvd     <= rd_hit ? {{(LFSR_W-PIDX_W){1'b0}}, rd_word[PIDX_W-1:0]} : lfsr;
          rem     <= '0;
          mod_cnt <= '0;
          state   <= S_MOD;
        end
        S_MOD: begin
          rem     <= rem_next;
          dvd     <= {dvd[LFSR_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (nopath_q) begin
              m_tdata <= '0;
              m_tuser <= 2'b10;
            end else begin
              m_tdata <= {{(OUT_TDATA_W-CORE_ADDR_W-PIDX_W){1'b0}}, rem, addr_sel};
              m_tuser <= {1'b0, !known_q};
              lfsr    <= lfsr_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/pfprr_checker.sv @@
// ----------------------------------------------------------------------------
// pfprr_checker
// Port-level checks for the per-flow round-robin path selector.
// ----------------------------------------------------------------------------
module pfprr_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [pfprr_pkg::IN_TDATA_W-1:0]     s_tdata,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [pfprr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic [pfprr_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import pfprr_pkg::*;

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // The table clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request accepted during table clearing");

  // Requests are worked on one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request accepted while one is in flight");

  // A no-path result carries a zero address, index zero and no new-flow flag.
  a_no_path_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("no-path result with nonzero payload");

  // A result appears only after the input was closed for a request in work.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a request");

endmodule

bind per_flow_path_round_robin pfprr_checker u_pfprr_checker (.*);
